// ===== design/seir_pkg.sv =====
// Shared types and constants of the SEIR node transition block.
package seir_pkg;

   // Health state coding of the request and response payloads
   typedef enum logic [1:0] {
      HEALTH_SUSCEPTIBLE = 2'd0,
      HEALTH_EXPOSED     = 2'd1,
      HEALTH_INFECTIOUS  = 2'd2,
      HEALTH_RECOVERED   = 2'd3
   } health_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SEED         = 2'd0,
      CSR_TRANSMISSION = 2'd1,
      CSR_INCUBATION   = 2'd2,
      CSR_RECOVERY     = 2'd3
   } csr_index_type;

   localparam int PERSON_WIDTH    = 24;
   localparam int DAY_WIDTH       = 16;
   localparam int COUNT_WIDTH     = 8;
   localparam int SEED_WIDTH      = 32;
   localparam int THRESHOLD_WIDTH = 54;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 54;

   // Most draws a susceptible person makes in one day
   localparam logic [COUNT_WIDTH-1:0] MAX_DEGREE = 8'd255;

   // Hash input weights and finalizer multipliers
   localparam logic [63:0] SEED_WEIGHT    = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] PERSON_WEIGHT  = 64'hD1B54A32D192ED03;
   localparam logic [63:0] DAY_WEIGHT     = 64'hA0761D6478BD642F;
   localparam logic [63:0] COUNTER_WEIGHT = 64'h8EBC6AF09C88C6E3;
   localparam logic [63:0] MIX1_MUL       = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX2_MUL       = 64'h94D049BB133111EB;

   // Job queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // One classified request: the draws to make and what a hit turns into
   typedef struct packed {
      logic [PERSON_WIDTH-1:0]    person;
      logic [DAY_WIDTH-1:0]       day;
      health_type                 cur;
      health_type                 on_hit;
      logic [COUNT_WIDTH-1:0]     draws;
      logic [THRESHOLD_WIDTH-1:0] threshold;
   } seir_job_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic not_empty;
   } seir_queue_status_type;

   // Hash engine sequencer states
   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_BASE0,
      ENG_BASE1,
      ENG_BASE2,
      ENG_BASE3,
      ENG_BASE4,
      ENG_BASE5,
      ENG_CNT_LO,
      ENG_CNT_HI,
      ENG_MIX1_A,
      ENG_MIX1_B,
      ENG_MIX1_C,
      ENG_MIX2_A,
      ENG_MIX2_B,
      ENG_MIX2_C,
      ENG_CHECK
   } eng_state_type;

endpackage

// ===== design/seir_front.sv =====
// Request front end: accepts a request and classifies it into a draw job.
module seir_front import seir_pkg::*; (
   input  logic                        start,
   output logic                        busy,
   input  logic [PERSON_WIDTH-1:0]     req_person_index,
   input  logic [DAY_WIDTH-1:0]        req_day,
   input  logic [1:0]                  req_current_state,
   input  logic [COUNT_WIDTH-1:0]      req_infectious_neighbours,
   input  logic [THRESHOLD_WIDTH-1:0]  transmission_threshold,
   input  logic [THRESHOLD_WIDTH-1:0]  incubation_threshold,
   input  logic [THRESHOLD_WIDTH-1:0]  recovery_threshold,
   input  seir_queue_status_type       queue_status,
   output logic                        push,
   output seir_job_type                job
);

   logic [COUNT_WIDTH-1:0] sat_count_w;

   // Stall requests while the queue is full
   assign busy = queue_status.full;
   assign push = start && !queue_status.full;

   // Clamp the neighbour count to the largest degree
   assign sat_count_w = (req_infectious_neighbours > MAX_DEGREE) ? MAX_DEGREE
                                                                 : req_infectious_neighbours;

   // Pick draw count, threshold and target state from the current state
   always_comb begin
      job.person = req_person_index;
      job.day    = req_day;
      job.cur    = health_type'(req_current_state);
      unique case (health_type'(req_current_state))
         HEALTH_SUSCEPTIBLE: begin
            job.on_hit    = HEALTH_EXPOSED;
            job.draws     = sat_count_w;
            job.threshold = transmission_threshold;
         end
         HEALTH_EXPOSED: begin
            job.on_hit    = HEALTH_INFECTIOUS;
            job.draws     = COUNT_WIDTH'(1);
            job.threshold = incubation_threshold;
         end
         HEALTH_INFECTIOUS: begin
            job.on_hit    = HEALTH_RECOVERED;
            job.draws     = COUNT_WIDTH'(1);
            job.threshold = recovery_threshold;
         end
         default: begin
            job.on_hit    = HEALTH_RECOVERED;
            job.draws     = '0;
            job.threshold = '0;
         end
      endcase
   end

endmodule

// ===== design/seir_queue.sv =====
// Short job queue between the front end and the hash engine.
module seir_queue import seir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  seir_job_type          push_job,
   input  logic                  pop,
   output seir_job_type          head_job,
   output seir_queue_status_type status
);

   seir_job_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job         = slot_ff[rd_ptr_ff];
   assign status.full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule

// ===== design/seir_engine.sv =====
// Hash engine: runs the draws of one job on a shared 32x32 multiplier.
module seir_engine import seir_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SEED_WIDTH-1:0] seed,
   input  seir_queue_status_type queue_status,
   input  seir_job_type          head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_next_state
);

   eng_state_type          state_ff, state_in;
   seir_job_type           job_ff, job_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [63:0]            base_ff, base_in;
   logic [63:0]            acc_ff, acc_in;
   logic [63:0]            x_ff, x_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   health_type             rsp_state_ff, rsp_state_in;

   logic [31:0] mul_a_w;
   logic [31:0] mul_b_w;
   logic [63:0] prod_w;
   logic [63:0] mix1_w;
   logic [63:0] mix2_w;
   logic [63:0] fin_w;
   logic        hit_w;
   logic        last_w;

   // Shared multiplier and the xor-shift steps of the finalizer
   assign prod_w = {32'b0, mul_a_w} * {32'b0, mul_b_w};
   assign mix1_w = acc_ff ^ (acc_ff >> 30);
   assign mix2_w = acc_ff ^ (acc_ff >> 27);
   assign fin_w  = acc_ff ^ (acc_ff >> 31);
   assign hit_w  = {1'b0, fin_w[63:11]} < job_ff.threshold;
   assign last_w = ({1'b0, cnt_ff} + 9'd1) == {1'b0, job_ff.draws};

   // Sequence the base sum, the counter term and the two multiply rounds
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      rsp_valid_in = 1'b0;
      rsp_state_in = rsp_state_ff;
      pop          = 1'b0;
      mul_a_w      = '0;
      mul_b_w      = '0;
      unique case (state_ff)
         ENG_IDLE: begin
            if (queue_status.not_empty) begin
               pop    = 1'b1;
               job_in = head_job;
               cnt_in = '0;
               if (head_job.draws == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_state_in = head_job.cur;
               end else begin
                  state_in = ENG_BASE0;
               end
            end
         end
         ENG_BASE0: begin
            mul_a_w  = seed;
            mul_b_w  = SEED_WEIGHT[31:0];
            acc_in   = prod_w;
            state_in = ENG_BASE1;
         end
         ENG_BASE1: begin
            mul_a_w  = seed;
            mul_b_w  = SEED_WEIGHT[63:32];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_BASE2;
         end
         ENG_BASE2: begin
            mul_a_w  = {8'b0, job_ff.person};
            mul_b_w  = PERSON_WEIGHT[31:0];
            acc_in   = acc_ff + prod_w;
            state_in = ENG_BASE3;
         end
         ENG_BASE3: begin
            mul_a_w  = {8'b0, job_ff.person};
            mul_b_w  = PERSON_WEIGHT[63:32];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_BASE4;
         end
         ENG_BASE4: begin
            mul_a_w  = {16'b0, job_ff.day};
            mul_b_w  = DAY_WEIGHT[31:0];
            acc_in   = acc_ff + prod_w;
            state_in = ENG_BASE5;
         end
         ENG_BASE5: begin
            mul_a_w  = {16'b0, job_ff.day};
            mul_b_w  = DAY_WEIGHT[63:32];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            base_in  = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_CNT_LO;
         end
         ENG_CNT_LO: begin
            mul_a_w  = {24'b0, cnt_ff};
            mul_b_w  = COUNTER_WEIGHT[31:0];
            acc_in   = base_ff + prod_w;
            state_in = ENG_CNT_HI;
         end
         ENG_CNT_HI: begin
            mul_a_w  = {24'b0, cnt_ff};
            mul_b_w  = COUNTER_WEIGHT[63:32];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_MIX1_A;
         end
         ENG_MIX1_A: begin
            x_in     = mix1_w;
            mul_a_w  = mix1_w[31:0];
            mul_b_w  = MIX1_MUL[31:0];
            acc_in   = prod_w;
            state_in = ENG_MIX1_B;
         end
         ENG_MIX1_B: begin
            mul_a_w  = x_ff[31:0];
            mul_b_w  = MIX1_MUL[63:32];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_MIX1_C;
         end
         ENG_MIX1_C: begin
            mul_a_w  = x_ff[63:32];
            mul_b_w  = MIX1_MUL[31:0];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_MIX2_A;
         end
         ENG_MIX2_A: begin
            x_in     = mix2_w;
            mul_a_w  = mix2_w[31:0];
            mul_b_w  = MIX2_MUL[31:0];
            acc_in   = prod_w;
            state_in = ENG_MIX2_B;
         end
         ENG_MIX2_B: begin
            mul_a_w  = x_ff[31:0];
            mul_b_w  = MIX2_MUL[63:32];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_MIX2_C;
         end
         ENG_MIX2_C: begin
            mul_a_w  = x_ff[63:32];
            mul_b_w  = MIX2_MUL[31:0];
            acc_in   = {acc_ff[63:32] + prod_w[31:0], acc_ff[31:0]};
            state_in = ENG_CHECK;
         end
         ENG_CHECK: begin
            // Stop on the first hit or after the last draw
            if (hit_w) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = job_ff.on_hit;
               state_in     = ENG_IDLE;
            end else if (last_w) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = job_ff.cur;
               state_in     = ENG_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ENG_CNT_LO;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the datapath between steps
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      cnt_ff       <= cnt_in;
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_state = rsp_state_ff;

   // A response only follows an idle pop or a final check
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ENG_IDLE || $past(state_ff) == ENG_CHECK))
      else $error("response strobe without a finished job");

   // The response is either the old state or the state a hit leads to
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_state_ff == job_ff.cur || rsp_state_ff == job_ff.on_hit))
      else $error("response state not reachable from the request");

   // The draw counter stays inside the job's draw count while busy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ENG_IDLE) |-> (cnt_ff < job_ff.draws))
      else $error("draw counter ran past the draw count");

   // A recovered person never changes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && job_ff.cur == HEALTH_RECOVERED) |-> (rsp_state_ff == HEALTH_RECOVERED))
      else $error("recovered person changed state");

endmodule

// ===== design/seir_node_transition_top.sv =====
// Top level of the SEIR node transition block: configuration and wiring.
//
// One request describes one person on one day: person index, day, current
// health state and the number of infectious neighbours. A request is taken
// at a rising edge with start high and busy low. The front end classifies it
// and puts it into a two-entry queue; busy rises only while that queue is full.
// The hash engine takes jobs from the queue and answers each with one response:
// rsp_valid is high for exactly one cycle with rsp_next_state alongside. The
// receiver cannot stall; responses come out in request order.
// The engine works on one job at a time on the single shared 32x32 multiplier.
// A recovered person, or a susceptible one with no infectious neighbour, is
// answered from the idle state; otherwise the engine forms the base sum and
// makes the draws, 1 for exposed and infectious people and up to the neighbour
// count for a susceptible person (stops at a hit). A request may wait behind
// earlier jobs. The csr_ port writes one of seed and the three thresholds per
// write; the user must write only while the block is idle, the block does not
// enforce this. Reset clears the configuration, the queue pointers and the engine
// state, emptying the queue; a request in flight is dropped with no response.
module seir_node_transition_top import seir_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [PERSON_WIDTH-1:0]    req_person_index,
   input  logic [DAY_WIDTH-1:0]       req_day,
   input  logic [1:0]                 req_current_state,
   input  logic [COUNT_WIDTH-1:0]     req_infectious_neighbours,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_next_state,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [SEED_WIDTH-1:0]      seed_ff;
   logic [THRESHOLD_WIDTH-1:0] transmission_ff;
   logic [THRESHOLD_WIDTH-1:0] incubation_ff;
   logic [THRESHOLD_WIDTH-1:0] recovery_ff;

   seir_queue_status_type queue_status;
   seir_job_type          push_job;
   seir_job_type          head_job;
   logic                  push;
   logic                  pop;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= '0;
         transmission_ff <= '0;
         incubation_ff   <= '0;
         recovery_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEED:         seed_ff         <= csr_write_data[SEED_WIDTH-1:0];
            CSR_TRANSMISSION: transmission_ff <= csr_write_data[THRESHOLD_WIDTH-1:0];
            CSR_INCUBATION:   incubation_ff   <= csr_write_data[THRESHOLD_WIDTH-1:0];
            CSR_RECOVERY:     recovery_ff     <= csr_write_data[THRESHOLD_WIDTH-1:0];
            default:          seed_ff         <= seed_ff;
         endcase
      end
   end

   seir_front u_front (
      .start                     (start),
      .busy                      (busy),
      .req_person_index          (req_person_index),
      .req_day                   (req_day),
      .req_current_state         (req_current_state),
      .req_infectious_neighbours (req_infectious_neighbours),
      .transmission_threshold    (transmission_ff),
      .incubation_threshold      (incubation_ff),
      .recovery_threshold        (recovery_ff),
      .queue_status              (queue_status),
      .push                      (push),
      .job                       (push_job)
   );

   seir_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   seir_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .queue_status   (queue_status),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_next_state (rsp_next_state)
   );

endmodule

// ===== bench/tb_seir_node_transition_top.sv =====
// Self-checking testbench of the SEIR node transition block.
`timescale 1ns / 100ps

module tb_seir_node_transition_top;
   import seir_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 100;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [THRESHOLD_WIDTH-1:0] THR_CERTAIN = 54'h20000000000000;
   localparam logic [THRESHOLD_WIDTH-1:0] THR_HALF    = 54'h10000000000000;
   localparam logic [THRESHOLD_WIDTH-1:0] THR_NEAR    = 54'h1FFFFFFFFFFFFF;
   localparam logic [THRESHOLD_WIDTH-1:0] THR_FULL    = 54'h3FFFFFFFFFFFFF;
   localparam logic [PERSON_WIDTH-1:0]    PERSON_MAX  = 24'hFFFFFF;
   localparam logic [DAY_WIDTH-1:0]       DAY_MAX     = 16'hFFFF;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   // One line of the directed stimulus: a register write or a request
   typedef struct packed {
      row_kind_type               kind;
      csr_index_type              idx;
      logic [CSR_DATA_WIDTH-1:0]  data;
      logic [PERSON_WIDTH-1:0]    person;
      logic [DAY_WIDTH-1:0]       day;
      health_type                 cur;
      logic [COUNT_WIDTH-1:0]     nbr;
      logic                       known;
      health_type                 want;
   } stim_row_type;

   // Expected next state of one accepted request
   typedef struct packed {
      logic [31:0] item;
      health_type  state;
   } expected_health_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [PERSON_WIDTH-1:0]    req_person_index = '0;
   logic [DAY_WIDTH-1:0]       req_day = '0;
   logic [1:0]                 req_current_state = '0;
   logic [COUNT_WIDTH-1:0]     req_infectious_neighbours = '0;
   logic                       rsp_valid;
   logic [1:0]                 rsp_next_state;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Shadow copy of the configuration registers
   logic [SEED_WIDTH-1:0]      seed_cfg = '0;
   logic [THRESHOLD_WIDTH-1:0] transmission_cfg = '0;
   logic [THRESHOLD_WIDTH-1:0] incubation_cfg = '0;
   logic [THRESHOLD_WIDTH-1:0] recovery_cfg = '0;

   expected_health_type expected_health_q[$];
   stim_row_type        directed_rows[$];
   int unsigned         accepted_count = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         stall_cycles = 0;
   bit                  gaps_enabled = 1'b1;

   seir_node_transition_top dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_person_index          (req_person_index),
      .req_day                   (req_day),
      .req_current_state         (req_current_state),
      .req_infectious_neighbours (req_infectious_neighbours),
      .rsp_valid                 (rsp_valid),
      .rsp_next_state            (rsp_next_state),
      .csr_write_enable          (csr_write_enable),
      .csr_index                 (csr_index),
      .csr_write_data            (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Top 53 bits of the mixed hash of seed, person, day and draw counter
   function automatic logic [52:0] splitmix_draw(input logic [PERSON_WIDTH-1:0] person,
                                                 input logic [DAY_WIDTH-1:0] day,
                                                 input logic [COUNT_WIDTH-1:0] counter);
      logic [63:0] h;
      h = {32'd0, seed_cfg} * SEED_WEIGHT + {40'd0, person} * PERSON_WEIGHT
        + {48'd0, day} * DAY_WEIGHT + {56'd0, counter} * COUNTER_WEIGHT;
      h = h ^ (h >> 30);
      h = h * MIX1_MUL;
      h = h ^ (h >> 27);
      h = h * MIX2_MUL;
      h = h ^ (h >> 31);
      return h[63:11];
   endfunction

   // Next health state of one person for one day
   function automatic health_type predict_next_health(input logic [PERSON_WIDTH-1:0] person,
                                                      input logic [DAY_WIDTH-1:0] day,
                                                      input health_type cur,
                                                      input logic [COUNT_WIDTH-1:0] nbr);
      health_type nxt;
      nxt = cur;
      case (cur)
         HEALTH_SUSCEPTIBLE: begin
            for (int k = 0; k < nbr && k < MAX_DEGREE; k++) begin
               if (nxt == HEALTH_SUSCEPTIBLE &&
                   {1'b0, splitmix_draw(person, day, k[COUNT_WIDTH-1:0])} < transmission_cfg)
                  nxt = HEALTH_EXPOSED;
            end
         end
         HEALTH_EXPOSED: begin
            if ({1'b0, splitmix_draw(person, day, '0)} < incubation_cfg)
               nxt = HEALTH_INFECTIOUS;
         end
         HEALTH_INFECTIOUS: begin
            if ({1'b0, splitmix_draw(person, day, '0)} < recovery_cfg)
               nxt = HEALTH_RECOVERED;
         end
         default: nxt = cur;
      endcase
      return nxt;
   endfunction

   // Hold one request until it is taken, then queue what it must produce
   task automatic send_request(input logic [PERSON_WIDTH-1:0] person,
                               input logic [DAY_WIDTH-1:0] day,
                               input health_type cur,
                               input logic [COUNT_WIDTH-1:0] nbr,
                               input logic known,
                               input health_type want);
      expected_health_type entry;
      entry.state = known ? want : predict_next_health(person, day, cur, nbr);
      start                     <= 1'b1;
      req_person_index          <= person;
      req_day                   <= day;
      req_current_state         <= cur;
      req_infectious_neighbours <= nbr;
      do @(posedge clock); while (busy);
      entry.item = accepted_count;
      accepted_count++;
      expected_health_q.insert(expected_health_q.size(), entry);
   endtask

   // When gaps are enabled, sometimes idle the sender for a random stretch, mostly short
   task automatic idle_sender();
      int unsigned r;
      r = $urandom_range(99);
      if (gaps_enabled && r >= 60) begin
         start <= 1'b0;
         if (r < 92)
            repeat ($urandom_range(3, 1)) @(posedge clock);
         else
            repeat ($urandom_range(40, 10)) @(posedge clock);
      end
   endtask

   // Drop start and wait until every pending response has come back
   task automatic drain_requests();
      start <= 1'b0;
      while (expected_health_q.size() != 0)
         @(posedge clock);
      repeat ($urandom_range(4, 2)) @(posedge clock);
   endtask

   // Write one register while the block is idle, and mirror it
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      drain_requests();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_SEED:         seed_cfg = data[SEED_WIDTH-1:0];
         CSR_TRANSMISSION: transmission_cfg = data;
         CSR_INCUBATION:   incubation_cfg = data;
         CSR_RECOVERY:     recovery_cfg = data;
         default: ;
      endcase
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      stim_row_type row;
      row      = '0;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = data;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_req(input logic [PERSON_WIDTH-1:0] person, input logic [DAY_WIDTH-1:0] day,
                          input health_type cur, input logic [COUNT_WIDTH-1:0] nbr,
                          input logic known, input health_type want);
      stim_row_type row;
      row        = '0;
      row.kind   = ROW_REQ;
      row.person = person;
      row.day    = day;
      row.cur    = cur;
      row.nbr    = nbr;
      row.known  = known;
      row.want   = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   function automatic logic [THRESHOLD_WIDTH-1:0] pick_threshold();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return THR_CERTAIN;
         2: return THR_FULL;
         3: return THR_NEAR;
         4: return 54'd1;
         5: return r[THRESHOLD_WIDTH-1:0];
         default: return THR_CERTAIN >> $urandom_range(6, 1) | (r[THRESHOLD_WIDTH-1:0] >> 8);
      endcase
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] pick_neighbours();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)
         return '0;
      else if (r < 85)
         return COUNT_WIDTH'($urandom_range(15, 1));
      else if (r < 95)
         return COUNT_WIDTH'($urandom_range(63, 16));
      else
         return COUNT_WIDTH'($urandom_range(255, 64));
   endfunction

   // Compare each response with the oldest pending expectation
   always @(posedge clock) begin
      expected_health_type entry;
      if (!reset && rsp_valid) begin
         if (expected_health_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: response %0d with no request pending", rsp_next_state);
         end else begin
            entry = expected_health_q.pop_front();
            if (rsp_next_state !== entry.state) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("ERROR: request %0d next_state expected %0d got %0d",
                           entry.item, entry.state, rsp_next_state);
            end
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("seir_node_transition_top regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type row;
      logic [31:0]  r_person;
      logic [31:0]  r_day;
      logic [31:0]  r_seed;

      // After reset every threshold is zero: nobody moves
      add_req('0, '0, HEALTH_SUSCEPTIBLE, 8'd0, 1'b1, HEALTH_SUSCEPTIBLE);
      add_req(PERSON_MAX, DAY_MAX, HEALTH_SUSCEPTIBLE, 8'd255, 1'b1, HEALTH_SUSCEPTIBLE);
      add_req('0, '0, HEALTH_EXPOSED, 8'd7, 1'b1, HEALTH_EXPOSED);
      add_req(PERSON_MAX, DAY_MAX, HEALTH_INFECTIOUS, 8'd255, 1'b1, HEALTH_INFECTIOUS);
      add_req('0, DAY_MAX, HEALTH_RECOVERED, 8'd255, 1'b1, HEALTH_RECOVERED);
      // Threshold of exactly one: every draw succeeds; seed write carries extra bits
      add_csr(CSR_SEED, THR_FULL);
      add_csr(CSR_TRANSMISSION, THR_CERTAIN);
      add_csr(CSR_INCUBATION, THR_CERTAIN);
      add_csr(CSR_RECOVERY, THR_CERTAIN);
      add_req(24'd1, 16'd1, HEALTH_SUSCEPTIBLE, 8'd1, 1'b1, HEALTH_EXPOSED);
      add_req(PERSON_MAX, DAY_MAX, HEALTH_SUSCEPTIBLE, 8'd255, 1'b1, HEALTH_EXPOSED);
      add_req(PERSON_MAX, '0, HEALTH_SUSCEPTIBLE, 8'd0, 1'b1, HEALTH_SUSCEPTIBLE);
      add_req('0, DAY_MAX, HEALTH_EXPOSED, 8'd0, 1'b1, HEALTH_INFECTIOUS);
      add_req(PERSON_MAX, '0, HEALTH_INFECTIOUS, 8'd0, 1'b1, HEALTH_RECOVERED);
      add_req(PERSON_MAX, DAY_MAX, HEALTH_RECOVERED, 8'd128, 1'b1, HEALTH_RECOVERED);
      // Thresholds at the top of the field
      add_csr(CSR_TRANSMISSION, THR_FULL);
      add_csr(CSR_INCUBATION, THR_FULL);
      add_csr(CSR_RECOVERY, THR_FULL);
      add_csr(CSR_SEED, '0);
      add_req(24'h5A5A5A, 16'hA5A5, HEALTH_SUSCEPTIBLE, 8'd200, 1'b1, HEALTH_EXPOSED);
      add_req(24'hA5A5A5, 16'h5A5A, HEALTH_EXPOSED, 8'd1, 1'b1, HEALTH_INFECTIOUS);
      add_req(24'h000001, 16'h8000, HEALTH_INFECTIOUS, 8'd3, 1'b1, HEALTH_RECOVERED);
      // Even odds: outcomes come from the hash
      add_csr(CSR_SEED, 54'h0000_0012_3456_789A);
      add_csr(CSR_TRANSMISSION, THR_HALF);
      add_csr(CSR_INCUBATION, THR_HALF);
      add_csr(CSR_RECOVERY, THR_HALF);
      add_req(24'd0, 16'd0, HEALTH_SUSCEPTIBLE, 8'd1, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(24'd17, 16'd3, HEALTH_SUSCEPTIBLE, 8'd8, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(PERSON_MAX, 16'd9, HEALTH_SUSCEPTIBLE, 8'd255, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(24'd42, DAY_MAX, HEALTH_EXPOSED, 8'd0, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(24'd43, 16'd100, HEALTH_INFECTIOUS, 8'd0, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(PERSON_MAX, DAY_MAX, HEALTH_EXPOSED, 8'd255, 1'b0, HEALTH_SUSCEPTIBLE);
      // Smallest nonzero transmission odds and near-certain progression
      add_csr(CSR_TRANSMISSION, 54'd1);
      add_csr(CSR_INCUBATION, THR_NEAR);
      add_csr(CSR_RECOVERY, THR_NEAR);
      add_req(24'h800000, 16'h0001, HEALTH_SUSCEPTIBLE, 8'd255, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(24'h123456, 16'h4321, HEALTH_EXPOSED, 8'd2, 1'b0, HEALTH_SUSCEPTIBLE);
      add_req(24'h654321, 16'h1234, HEALTH_INFECTIOUS, 8'd2, 1'b0, HEALTH_SUSCEPTIBLE);

      // Hold reset, then release it
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            write_register(row.idx, row.data);
         end else begin
            send_request(row.person, row.day, row.cur, row.nbr, row.known, row.want);
            idle_sender();
         end
      end

      // Random phases, each under a fresh register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         gaps_enabled = (ph % 4 != 1);
         r_seed = $urandom;
         case (ph % 5)
            0: write_register(CSR_SEED, '0);
            1: write_register(CSR_SEED, {22'h3FFFFF, 32'hFFFFFFFF});
            default: write_register(CSR_SEED, {r_seed[21:0], $urandom});
         endcase
         write_register(CSR_TRANSMISSION, pick_threshold());
         write_register(CSR_INCUBATION, pick_threshold());
         write_register(CSR_RECOVERY, pick_threshold());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r_person = $urandom;
            r_day    = $urandom;
            if ($urandom_range(4) == 0)
               r_person = $urandom_range(15);
            send_request(r_person[PERSON_WIDTH-1:0], r_day[DAY_WIDTH-1:0],
                         health_type'($urandom_range(3)), pick_neighbours(),
                         1'b0, HEALTH_SUSCEPTIBLE);
            if ($urandom_range(49) == 0)
               drain_requests();
            else
               idle_sender();
         end
      end

      // Let the last responses drain, then settle
      drain_requests();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("seir_node_transition_top regression: pass");
      end else begin
         $display("seir_node_transition_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/seir_pkg.sv
design/seir_front.sv
design/seir_queue.sv
design/seir_engine.sv
design/seir_node_transition_top.sv
bench/tb_seir_node_transition_top.sv
